[src/hash_table_linear_probe_macros.svh]
// Assertion macros for the RTL
`ifndef HASH_TABLE_LINEAR_PROBE_MACROS_SVH
`define HASH_TABLE_LINEAR_PROBE_MACROS_SVH

`ifndef SYNTHESIS
`define HTLP_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hash table check failed");
`define HTLP_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hash table check failed");
`else
`define HTLP_ASSERT_IMPL(name, ante, cons)
`define HTLP_ASSERT_NEXT(name, ante, cons)
`endif

`endif

[src/htlp_pkg.sv]
package htlp_pkg;

    typedef enum logic [1:0] {
        MODE_INSERT,
        MODE_DELETE,
        MODE_GET,
        MODE_UPDATE
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_FULL,
        ST_KEY_LONG,
        ST_PAY_LONG,
        ST_ZERO_LEN,
        ST_NOT_FOUND
    } status_t;

    localparam logic [1:0] REG_SLOTS   = 2'd0;
    localparam logic [1:0] REG_MAX_KEY = 2'd1;
    localparam logic [1:0] REG_MAX_PAY = 2'd2;

    localparam logic [6:0] RST_SLOTS   = 7'd64;
    localparam logic [3:0] RST_MAX_KEY = 4'd8;
    localparam logic [3:0] RST_MAX_PAY = 4'd8;

    localparam logic [31:0] HASH_SEED = 32'd5381;

    // clamped register values
    typedef struct packed {
        logic [6:0] slots;
        logic [3:0] max_key;
        logic [3:0] max_pay;
    } cfg_t;

    typedef struct packed {
        mode_t       mode;
        logic [63:0] key;
        logic [3:0]  key_length;
        logic [63:0] payload;
        logic [3:0]  payload_length;
        status_t     pre_status;
    } job_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_HASH,
        F_MOD,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_SCAN,
        B_PAY_USE
    } back_state_t;

    function automatic logic [63:0] byte_mask(input logic [3:0] n);
        logic [63:0] m;
        for (int i = 0; i < 8; i++)
        begin
            m[8*i +: 8] = (4'(i) < n) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

[src/hash_table_linear_probe.sv]
// Key/payload table with djb2 hashing and linear probing.
// Commands: drive mode, key, key_length, payload and payload_length with start
// high; the command is taken on a clock edge where busy is low. Each command
// gives exactly one result beat: done is high for one cycle with status,
// payload_out, slot_index and entries_held. The receiver cannot stall it.
// A front end checks lengths, hashes the key of an insert (one key byte a cycle,
// then a bit-serial remainder by slots_in_use), and hands the command through a
// two-entry queue to the back end, which reads one slot a cycle from the key RAM.
// The front end can take a new command once it has handed the last one to the
// queue, so front and back overlap; the back end works on one command at a time.
// After reset the key RAM is cleared one slot a cycle with busy held high;
// the registers accept writes throughout.
// Registers (APB, word addresses): 0 slots_in_use, 1 max_key_bytes,
// 2 max_payload_bytes; write them only while the table is idle.
`include "hash_table_linear_probe_macros.svh"

module hash_table_linear_probe
    import htlp_pkg::*;
#(
    parameter int SLOTS         = 64,
    parameter int KEY_BYTES     = 8,
    parameter int PAYLOAD_BYTES = 8,
    localparam int SLOT_W       = $clog2(SLOTS),
    localparam int CNT_W        = $clog2(SLOTS + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        mode,
    input  logic [63:0]       key,
    input  logic [3:0]        key_length,
    input  logic [63:0]       payload,
    input  logic [3:0]        payload_length,
    output logic              done,
    output logic [2:0]        status,
    output logic [63:0]       payload_out,
    output logic [SLOT_W-1:0] slot_index,
    output logic [CNT_W-1:0]  entries_held,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int QDEPTH = 2;

    logic [6:0] slots_reg;
    logic [3:0] max_key_reg, max_pay_reg;
    cfg_t       cfg;
    logic       cfg_wr;

    logic              clearing, q_push, q_full, q_pop, q_empty;
    job_t              f_job, b_job;
    logic [SLOT_W-1:0] f_idx, b_idx;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg   <= RST_SLOTS;
            max_key_reg <= RST_MAX_KEY;
            max_pay_reg <= RST_MAX_PAY;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_SLOTS:   slots_reg   <= pwdata[6:0];
                REG_MAX_KEY: max_key_reg <= pwdata[3:0];
                REG_MAX_PAY: max_pay_reg <= pwdata[3:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_SLOTS:   prdata = {25'd0, slots_reg};
            REG_MAX_KEY: prdata = {28'd0, max_key_reg};
            REG_MAX_PAY: prdata = {28'd0, max_pay_reg};
            default:     prdata = '0;
        endcase
    end

    // zero acts as one, anything above the build size acts as the build size
    always_comb
    begin
        cfg.slots   = (slots_reg == '0) ? 7'd1
                      : ((32'(slots_reg) > SLOTS) ? 7'(SLOTS) : slots_reg);
        cfg.max_key = (max_key_reg == '0) ? 4'd1
                      : ((32'(max_key_reg) > KEY_BYTES) ? 4'(KEY_BYTES) : max_key_reg);
        cfg.max_pay = (max_pay_reg == '0) ? 4'd1
                      : ((32'(max_pay_reg) > PAYLOAD_BYTES) ? 4'(PAYLOAD_BYTES) : max_pay_reg);
    end

    htlp_front #(.SLOT_W(SLOT_W)) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .mode           (mode),
        .key            (key),
        .key_length     (key_length),
        .payload        (payload),
        .payload_length (payload_length),
        .cfg            (cfg),
        .hold           (clearing),
        .busy           (busy),
        .push           (q_push),
        .push_job       (f_job),
        .push_idx       (f_idx),
        .full           (q_full)
    );

    htlp_fifo #(.W($bits(job_t) + SLOT_W), .DEPTH(QDEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({f_idx, f_job}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  ({b_idx, b_job}),
        .empty     (q_empty)
    );

    htlp_back #(
        .SLOTS         (SLOTS),
        .KEY_BYTES     (KEY_BYTES),
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .job          (b_job),
        .job_idx      (b_idx),
        .empty        (q_empty),
        .pop          (q_pop),
        .clearing     (clearing),
        .done         (done),
        .status       (status),
        .payload_out  (payload_out),
        .slot_index   (slot_index),
        .entries_held (entries_held)
    );

    `HTLP_ASSERT_IMPL(a_fail_clean, done && (status != ST_OK), (slot_index == '0) && (payload_out == '0))
    `HTLP_ASSERT_NEXT(a_take_busy, start && !busy, busy)
    `HTLP_ASSERT_IMPL(a_count_cap, done, entries_held <= CNT_W'(SLOTS))
    `HTLP_ASSERT_IMPL(a_clear_busy, clearing, busy && !done)

endmodule

[src/htlp_ram.sv]
module htlp_ram #(
    parameter int W     = 64,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/htlp_fifo.sv]
module htlp_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2,
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         empty
);

    logic [W-1:0]  entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] cnt_reg;

    assign full     = (cnt_reg == CW'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_reg + 1'b1);
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_reg + 1'b1);
            end
            if ((push && !full) && !(pop && !empty))
            begin
                cnt_reg <= CW'(cnt_reg + 1'b1);
            end
            else if (!(push && !full) && (pop && !empty))
            begin
                cnt_reg <= CW'(cnt_reg - 1'b1);
            end
        end
    end

endmodule

[src/htlp_front.sv]
module htlp_front
    import htlp_pkg::*;
#(
    parameter int SLOT_W = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        mode,
    input  logic [63:0]       key,
    input  logic [3:0]        key_length,
    input  logic [63:0]       payload,
    input  logic [3:0]        payload_length,
    input  cfg_t              cfg,
    input  logic              hold,
    output logic              busy,
    output logic              push,
    output job_t              push_job,
    output logic [SLOT_W-1:0] push_idx,
    input  logic              full
);

    front_state_t state_reg, state_next;
    job_t         job_reg, job_next;
    logic [31:0]  h_reg, h_next;
    logic [31:0]  mag_reg, mag_next;
    logic [6:0]   rem_reg, rem_next;
    logic [3:0]   byte_cnt_reg, byte_cnt_next;
    logic [4:0]   bit_cnt_reg, bit_cnt_next;

    logic         accept;
    logic [7:0]   key_byte;
    logic [31:0]  h_step;
    logic [7:0]   trial;
    status_t      pre;
    mode_t        mode_in;

    assign busy     = (state_reg != F_IDLE) || hold;
    assign accept   = start && !busy;
    assign push_job = job_reg;
    assign push_idx = SLOT_W'(rem_reg);
    assign mode_in  = mode_t'(mode);

    assign key_byte = job_reg.key[{byte_cnt_reg[2:0], 3'b000} +: 8];
    assign h_step   = (h_reg << 5) + h_reg + {{24{key_byte[7]}}, key_byte};
    assign trial    = {rem_reg, mag_reg[31]};

    // length checks; the full check needs the live count and sits in the back end
    always_comb
    begin
        pre = ST_OK;
        if (mode_in == MODE_INSERT)
        begin
            if (key_length > cfg.max_key)
                pre = ST_KEY_LONG;
            else if (payload_length > cfg.max_pay)
                pre = ST_PAY_LONG;
            else if (key_length == '0 || payload_length == '0)
                pre = ST_ZERO_LEN;
        end
        else
        begin
            if (key_length == '0)
                pre = ST_ZERO_LEN;
            else if (mode_in == MODE_UPDATE && payload_length == '0)
                pre = ST_ZERO_LEN;
            else if (mode_in == MODE_UPDATE && payload_length > cfg.max_pay)
                pre = ST_PAY_LONG;
            else if (key_length > cfg.max_key)
                pre = ST_NOT_FOUND;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        job_next      = job_reg;
        h_next        = h_reg;
        mag_next      = mag_reg;
        rem_next      = rem_reg;
        byte_cnt_next = byte_cnt_reg;
        bit_cnt_next  = bit_cnt_reg;
        push          = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    job_next.mode           = mode_in;
                    job_next.key            = key;
                    job_next.key_length     = key_length;
                    job_next.payload        = payload;
                    job_next.payload_length = payload_length;
                    job_next.pre_status     = pre;
                    h_next        = HASH_SEED;
                    byte_cnt_next = '0;
                    rem_next      = '0;
                    if (mode_in == MODE_INSERT && pre == ST_OK)
                        state_next = F_HASH;
                    else
                        state_next = F_PUSH;
                end
            end
            F_HASH:
            begin
                h_next        = h_step;
                byte_cnt_next = 4'(byte_cnt_reg + 4'd1);
                if (4'(byte_cnt_reg + 4'd1) == job_reg.key_length)
                begin
                    mag_next     = h_step[31] ? (32'd0 - h_step) : h_step;
                    rem_next     = '0;
                    bit_cnt_next = '0;
                    state_next   = F_MOD;
                end
            end
            F_MOD:
            begin
                // restoring remainder, one dividend bit a cycle
                if (trial >= {1'b0, cfg.slots})
                    rem_next = 7'(trial - {1'b0, cfg.slots});
                else
                    rem_next = 7'(trial);
                mag_next     = {mag_reg[30:0], 1'b0};
                bit_cnt_next = 5'(bit_cnt_reg + 5'd1);
                if (bit_cnt_reg == 5'd31)
                    state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!full)
                begin
                    push       = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        h_reg        <= h_next;
        mag_reg      <= mag_next;
        rem_reg      <= rem_next;
        byte_cnt_reg <= byte_cnt_next;
        bit_cnt_reg  <= bit_cnt_next;
    end

endmodule

[src/htlp_back.sv]
module htlp_back
    import htlp_pkg::*;
#(
    parameter int SLOTS         = 64,
    parameter int KEY_BYTES     = 8,
    parameter int PAYLOAD_BYTES = 8,
    localparam int SLOT_W       = $clog2(SLOTS),
    localparam int CNT_W        = $clog2(SLOTS + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  job_t              job,
    input  logic [SLOT_W-1:0] job_idx,
    input  logic              empty,
    output logic              pop,
    output logic              clearing,
    output logic              done,
    output logic [2:0]        status,
    output logic [63:0]       payload_out,
    output logic [SLOT_W-1:0] slot_index,
    output logic [CNT_W-1:0]  entries_held
);

    localparam int KW = 8 * KEY_BYTES;
    localparam int PW = 8 * PAYLOAD_BYTES;

    back_state_t       state_reg, state_next;
    job_t              job_reg, job_next;
    logic [SLOT_W-1:0] iss_addr_reg, iss_addr_next;
    logic [CNT_W-1:0]  iss_cnt_reg, iss_cnt_next;
    logic [CNT_W-1:0]  chk_cnt_reg, chk_cnt_next;
    logic              rd_pend_reg, rd_pend_next;
    logic [SLOT_W-1:0] rd_slot_reg, rd_slot_next;
    logic [SLOT_W-1:0] hit_slot_reg, hit_slot_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SLOT_W-1:0] clr_addr_reg, clr_addr_next;
    logic              done_reg, done_next;
    status_t           status_reg, status_next;
    logic [63:0]       pout_reg, pout_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    logic              key_we, key_re, pay_we, pay_re;
    logic [SLOT_W-1:0] key_waddr, key_raddr, pay_waddr, pay_raddr;
    logic [KW-1:0]     key_wdata, key_rdata;
    logic [PW-1:0]     pay_wdata, pay_rdata;

    logic [CNT_W-1:0]  ns;
    logic [63:0]       key_word, pay_word, qmask, pmask;
    logic              key_vacant, slot_match, hit;

    htlp_ram #(.W(KW), .DEPTH(SLOTS)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .re    (key_re),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    htlp_ram #(.W(PW), .DEPTH(SLOTS)) u_pay_ram (
        .clk   (clk),
        .we    (pay_we),
        .waddr (pay_waddr),
        .wdata (pay_wdata),
        .re    (pay_re),
        .raddr (pay_raddr),
        .rdata (pay_rdata)
    );

    assign ns         = CNT_W'(cfg.slots);
    assign key_word   = 64'(key_rdata);
    assign pay_word   = 64'(pay_rdata);
    assign qmask      = byte_mask(job_reg.key_length);
    assign pmask      = byte_mask(job_reg.payload_length);
    assign key_vacant = (key_word & byte_mask(cfg.max_key)) == '0;
    assign slot_match = (key_word & qmask) == (job_reg.key & qmask);
    assign hit        = rd_pend_reg && ((job_reg.mode == MODE_INSERT) ? key_vacant
                                                                      : (!key_vacant && slot_match));

    assign clearing     = (state_reg == B_CLEAR);
    assign done         = done_reg;
    assign status       = status_reg;
    assign payload_out  = pout_reg;
    assign slot_index   = slot_reg;
    assign entries_held = count_reg;

    always_comb
    begin
        state_next    = state_reg;
        job_next      = job_reg;
        iss_addr_next = iss_addr_reg;
        iss_cnt_next  = iss_cnt_reg;
        chk_cnt_next  = chk_cnt_reg;
        rd_pend_next  = 1'b0;
        rd_slot_next  = rd_slot_reg;
        hit_slot_next = hit_slot_reg;
        count_next    = count_reg;
        clr_addr_next = clr_addr_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        pout_next     = pout_reg;
        slot_next     = slot_reg;
        pop           = 1'b0;
        key_we        = 1'b0;
        key_waddr     = rd_slot_reg;
        key_wdata     = '0;
        key_re        = 1'b0;
        key_raddr     = iss_addr_reg;
        pay_we        = 1'b0;
        pay_waddr     = rd_slot_reg;
        pay_wdata     = '0;
        pay_re        = 1'b0;
        pay_raddr     = rd_slot_reg;
        case (state_reg)
            B_CLEAR:
            begin
                key_we        = 1'b1;
                key_waddr     = clr_addr_reg;
                clr_addr_next = SLOT_W'(clr_addr_reg + 1'b1);
                if (clr_addr_reg == SLOT_W'(SLOTS - 1))
                    state_next = B_IDLE;
            end
            B_IDLE:
            begin
                if (!empty)
                begin
                    pop      = 1'b1;
                    job_next = job;
                    if (job.mode == MODE_INSERT && count_reg >= ns)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_FULL;
                        pout_next   = '0;
                        slot_next   = '0;
                    end
                    else if (job.pre_status != ST_OK)
                    begin
                        done_next   = 1'b1;
                        status_next = job.pre_status;
                        pout_next   = '0;
                        slot_next   = '0;
                    end
                    else
                    begin
                        iss_addr_next = (job.mode == MODE_INSERT) ? job_idx : '0;
                        iss_cnt_next  = '0;
                        chk_cnt_next  = '0;
                        state_next    = B_SCAN;
                    end
                end
            end
            B_SCAN:
            begin
                // reads every cycle up to ns; check trails a register
                if (hit)
                begin
                    hit_slot_next = rd_slot_reg;
                    case (job_reg.mode)
                        MODE_INSERT:
                        begin
                            key_we      = 1'b1;
                            key_wdata   = KW'(job_reg.key & qmask);
                            pay_we      = 1'b1;
                            pay_wdata   = PW'(job_reg.payload & pmask);
                            count_next  = CNT_W'(count_reg + 1'b1);
                            done_next   = 1'b1;
                            status_next = ST_OK;
                            pout_next   = '0;
                            slot_next   = rd_slot_reg;
                            state_next  = B_IDLE;
                        end
                        MODE_DELETE:
                        begin
                            key_we      = 1'b1;
                            key_wdata   = '0;
                            count_next  = (count_reg == '0) ? '0 : CNT_W'(count_reg - 1'b1);
                            done_next   = 1'b1;
                            status_next = ST_OK;
                            pout_next   = '0;
                            slot_next   = rd_slot_reg;
                            state_next  = B_IDLE;
                        end
                        default:
                        begin
                            pay_re     = 1'b1;
                            state_next = B_PAY_USE;
                        end
                    endcase
                end
                else
                begin
                    if (rd_pend_reg)
                    begin
                        chk_cnt_next = CNT_W'(chk_cnt_reg + 1'b1);
                        if (CNT_W'(chk_cnt_reg + 1'b1) == ns)
                        begin
                            done_next   = 1'b1;
                            status_next = (job_reg.mode == MODE_INSERT) ? ST_FULL : ST_NOT_FOUND;
                            pout_next   = '0;
                            slot_next   = '0;
                            state_next  = B_IDLE;
                        end
                    end
                    if (iss_cnt_reg < ns)
                    begin
                        key_re        = 1'b1;
                        rd_pend_next  = 1'b1;
                        rd_slot_next  = iss_addr_reg;
                        iss_cnt_next  = CNT_W'(iss_cnt_reg + 1'b1);
                        iss_addr_next = (iss_addr_reg == SLOT_W'(ns - 1'b1)) ? '0
                                        : SLOT_W'(iss_addr_reg + 1'b1);
                    end
                end
            end
            B_PAY_USE:
            begin
                done_next   = 1'b1;
                status_next = ST_OK;
                slot_next   = hit_slot_reg;
                state_next  = B_IDLE;
                if (job_reg.mode == MODE_GET)
                begin
                    pout_next = pay_word & byte_mask(cfg.max_pay);
                end
                else
                begin
                    pout_next = '0;
                    pay_we    = 1'b1;
                    pay_waddr = hit_slot_reg;
                    pay_wdata = PW'((pay_word & ~pmask) | (job_reg.payload & pmask));
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_CLEAR;
            clr_addr_reg <= '0;
            count_reg    <= '0;
            done_reg     <= 1'b0;
            rd_pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            count_reg    <= count_next;
            done_reg     <= done_next;
            rd_pend_reg  <= rd_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        iss_addr_reg <= iss_addr_next;
        iss_cnt_reg  <= iss_cnt_next;
        chk_cnt_reg  <= chk_cnt_next;
        rd_slot_reg  <= rd_slot_next;
        hit_slot_reg <= hit_slot_next;
        status_reg   <= status_next;
        pout_reg     <= pout_next;
        slot_reg     <= slot_next;
    end

endmodule
